@@ design/shms_pkg.sv @@
// Shared types, codes and constants of the sensor health and mode supervisor.
`timescale 1ns / 1ps

package shms_pkg;

  // Event codes on the command field.
  typedef enum logic [2:0] {
    CMD_DIAG  = 3'd0,
    CMD_GNSS  = 3'd1,
    CMD_IMU   = 3'd2,
    CMD_WHEEL = 3'd3,
    CMD_EVAL  = 3'd4
  } cmd_t;

  // Operating modes reported on evaluate.
  typedef enum logic [1:0] {
    MODE_INVALID        = 2'd0,
    MODE_DEAD_RECKONING = 2'd1,
    MODE_DEGRADED       = 2'd2,
    MODE_NORMAL         = 2'd3
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_GNSS_TIMEOUT   = 3'd0,
    REG_IMU_TIMEOUT    = 3'd1,
    REG_WHEEL_TIMEOUT  = 3'd2,
    REG_INNOV_WARN     = 3'd3,
    REG_INNOV_FAIL     = 3'd4,
    REG_COV_LIMIT      = 3'd5,
    REG_JUMP_LIMIT     = 3'd6,
    REG_MAX_FIX_PERIOD = 3'd7
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int JUMP_W     = 20;

  // Register reset values.
  localparam logic [31:0] GNSS_TIMEOUT_RST   = 32'd1000000;
  localparam logic [31:0] IMU_TIMEOUT_RST    = 32'd500000;
  localparam logic [31:0] WHEEL_TIMEOUT_RST  = 32'd500000;
  localparam logic [31:0] INNOV_WARN_RST     = 32'd196608;
  localparam logic [31:0] INNOV_FAIL_RST     = 32'd393216;
  localparam logic [31:0] COV_LIMIT_RST      = 32'd19661;
  localparam logic [19:0] JUMP_LIMIT_RST     = 20'd1000;
  localparam logic [31:0] MAX_FIX_PERIOD_RST = 32'd500000;

  // Fix spacing that a valid period must exceed.
  localparam logic [47:0] MIN_PERIOD_US = 48'd1000;

  // Confidence in hundredths and the penalties taken from it.
  localparam logic [7:0] CONF_FULL   = 8'd100;
  localparam logic [7:0] PEN_GNSS    = 8'd35;
  localparam logic [7:0] PEN_WHEEL   = 8'd15;
  localparam logic [7:0] PEN_IMU     = 8'd40;
  localparam logic [7:0] PEN_INNOV   = 8'd20;
  localparam logic [7:0] PEN_COV     = 8'd15;
  localparam logic [7:0] PEN_JUMP    = 8'd15;
  localparam logic [7:0] PEN_RATE    = 8'd10;

  // Default depth of the check queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 4;

  // One input item.
  typedef struct packed {
    logic [2:0]         command;
    logic [47:0]        stamp_us;
    logic signed [31:0] pos_x_mm;
    logic signed [31:0] pos_y_mm;
    logic [31:0]        cov_xx;
    logic [31:0]        cov_yy;
    logic               gnss_accepted;
    logic               wheel_accepted;
    logic [31:0]        gnss_innovation;
    logic [31:0]        wheel_innovation;
  } item_t;

  // Check outcomes of one evaluate, passed from front to back.
  typedef struct packed {
    logic        imu_ok;
    logic        gnss_recent;
    logic        wheel_recent;
    logic        diag_gnss_ok;
    logic        diag_wheel_ok;
    logic        diag_seen;
    logic        cov_ok;
    logic        rate_ok;
    logic        jump_ok;
    logic        innov_warn;
    logic        innov_fail;
    logic [31:0] gnss_innov;
    logic [31:0] wheel_innov;
  } check_t;

  // One result item.
  typedef struct packed {
    mode_t       mode;
    logic [6:0]  confidence;
    logic        gnss_trusted;
    logic        imu_good;
    logic        wheel_trusted;
    logic        healthy;
    logic [31:0] gnss_innovation_out;
    logic [31:0] wheel_innovation_out;
  } result_t;

endpackage

@@ design/sensor_health_mode_supervisor.sv @@
// Top level of the sensor health and mode supervisor.
`timescale 1ns / 1ps

// Usage:
// Events enter through a queue-style port: an item transfers on a clock edge with push
// high and full low. Diagnostics, GNSS fix, IMU and wheel commands update the stored
// sensor state and give no result; unused command codes are dropped. An evaluate
// command yields one result item, read while empty is low and transferred on a clock
// edge with pop high.
// Throughput is one item per cycle while full is low. An evaluate result reaches the
// result ports through the two stages of the GNSS jump squaring pipeline in the front
// (the first loads at the transfer edge), the check queue and the output register.
// When the receiver stalls, results collect in the check queue; full rises once the
// queue and the front pipeline hold QUEUE_DEPTH evaluates, and input transfers wait.
// Configuration writes take effect on the next edge and must be made while the block
// is idle; the block itself does not enforce this. Synchronous reset restores the
// register defaults, clears all sensor state, sets the fix period to all ones and
// empties the queue and the output register.
module sensor_health_mode_supervisor #(
  parameter int QUEUE_DEPTH = shms_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [2:0]                      command,
  input  logic [47:0]                     stamp_us,
  input  logic signed [31:0]              pos_x_mm,
  input  logic signed [31:0]              pos_y_mm,
  input  logic [31:0]                     cov_xx,
  input  logic [31:0]                     cov_yy,
  input  logic                            gnss_accepted,
  input  logic                            wheel_accepted,
  input  logic [31:0]                     gnss_innovation,
  input  logic [31:0]                     wheel_innovation,
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      mode,
  output logic [6:0]                      confidence,
  output logic                            gnss_trusted,
  output logic                            imu_good,
  output logic                            wheel_trusted,
  output logic                            healthy,
  output logic [31:0]                     gnss_innovation_out,
  output logic [31:0]                     wheel_innovation_out,
  input  logic                            cfg_we,
  input  logic [shms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shms_pkg::CFG_DATA_W-1:0] cfg_data
);
  import shms_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH+1);

  item_t         item;
  logic          accept;
  logic          check_push;
  check_t        check_in;
  check_t        check_head;
  logic          check_pop;
  logic          check_empty;
  logic [CW-1:0] check_count;
  logic [1:0]    eval_inflight;
  logic [CW:0]   occupancy;
  result_t       result;

  // Gather the input fields into one item.
  always_comb begin
    item.command          = command;
    item.stamp_us         = stamp_us;
    item.pos_x_mm         = pos_x_mm;
    item.pos_y_mm         = pos_y_mm;
    item.cov_xx           = cov_xx;
    item.cov_yy           = cov_yy;
    item.gnss_accepted    = gnss_accepted;
    item.wheel_accepted   = wheel_accepted;
    item.gnss_innovation  = gnss_innovation;
    item.wheel_innovation = wheel_innovation;
  end

  // Credit: queue entries plus evaluates still in the front pipeline.
  assign occupancy = {1'b0, check_count} + (CW+1)'(eval_inflight);
  assign full      = occupancy >= (CW+1)'(QUEUE_DEPTH);
  assign accept    = push && !full;

  shms_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .item          (item),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .check_push    (check_push),
    .check         (check_in),
    .eval_inflight (eval_inflight)
  );

  shms_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (check_push),
    .din   (check_in),
    .pop   (check_pop),
    .dout  (check_head),
    .empty (check_empty),
    .count (check_count)
  );

  shms_back u_back (
    .clk         (clk),
    .rst         (rst),
    .check_empty (check_empty),
    .check       (check_head),
    .check_pop   (check_pop),
    .pop         (pop),
    .empty       (empty),
    .result      (result)
  );

  // Spread the result item onto its ports.
  assign mode                 = result.mode;
  assign confidence           = result.confidence;
  assign gnss_trusted         = result.gnss_trusted;
  assign imu_good             = result.imu_good;
  assign wheel_trusted        = result.wheel_trusted;
  assign healthy              = result.healthy;
  assign gnss_innovation_out  = result.gnss_innovation_out;
  assign wheel_innovation_out = result.wheel_innovation_out;

endmodule

@@ design/shms_front.sv @@
// Front part: configuration, sensor state, event handling and evaluate checks.
`timescale 1ns / 1ps

module shms_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  shms_pkg::item_t               item,
  input  logic                          cfg_we,
  input  logic [shms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shms_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          check_push,
  output shms_pkg::check_t              check,
  output logic [1:0]                    eval_inflight
);
  import shms_pkg::*;

  // Freshness: the stored stamp lies ahead of now, or its age is within the timeout.
  function automatic logic is_fresh(input logic [47:0] now, input logic [47:0] last,
                                    input logic [31:0] timeout);
    logic [48:0] diff;
    diff = {1'b0, now} - {1'b0, last};
    return diff[48] || (diff[47:0] <= {16'd0, timeout});
  endfunction

  // Magnitude of the difference of two signed positions.
  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    logic [32:0] m;
    d = {a[31], a} - {b[31], b};
    m = d[32] ? (~d + 33'd1) : d;
    return m[31:0];
  endfunction

  logic [31:0] gnss_timeout_us;
  logic [31:0] imu_timeout_us;
  logic [31:0] wheel_timeout_us;
  logic [31:0] innovation_warn;
  logic [31:0] innovation_fail;
  logic [31:0] cov_trace_limit;
  logic [JUMP_W-1:0] jump_limit_mm;
  logic [31:0] max_fix_period_us;
  logic [2*JUMP_W-1:0] jump_limit_sq;

  logic        diag_gnss_ok;
  logic        diag_wheel_ok;
  logic [31:0] diag_gnss_innov;
  logic [31:0] diag_wheel_innov;
  logic        diag_seen;
  logic [47:0] gnss_stamp;
  logic [47:0] imu_stamp;
  logic [47:0] wheel_stamp;
  logic [32:0] cov_trace;
  logic        have_prev_fix;
  logic [31:0] prev_x;
  logic [31:0] prev_y;
  logic [63:0] jump_sq;
  logic [47:0] fix_period;

  logic        s1_fix;
  logic        s1_eval;
  logic [31:0] s1_mag_x;
  logic [31:0] s1_mag_y;
  check_t      s1_check;
  logic        s1_have_prev;

  logic        s2_fix;
  logic        s2_eval;
  logic [63:0] s2_sq_x;
  logic [63:0] s2_sq_y;
  check_t      s2_check;
  logic        s2_have_prev;

  cmd_t        cmd;
  logic [48:0] period;
  logic        period_valid;
  check_t      eval_check;
  logic [64:0] jump_sum;

  assign cmd = cmd_t'(item.command);

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      gnss_timeout_us   <= GNSS_TIMEOUT_RST;
      imu_timeout_us    <= IMU_TIMEOUT_RST;
      wheel_timeout_us  <= WHEEL_TIMEOUT_RST;
      innovation_warn   <= INNOV_WARN_RST;
      innovation_fail   <= INNOV_FAIL_RST;
      cov_trace_limit   <= COV_LIMIT_RST;
      jump_limit_mm     <= JUMP_LIMIT_RST;
      max_fix_period_us <= MAX_FIX_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_GNSS_TIMEOUT:   gnss_timeout_us   <= cfg_data;
        REG_IMU_TIMEOUT:    imu_timeout_us    <= cfg_data;
        REG_WHEEL_TIMEOUT:  wheel_timeout_us  <= cfg_data;
        REG_INNOV_WARN:     innovation_warn   <= cfg_data;
        REG_INNOV_FAIL:     innovation_fail   <= cfg_data;
        REG_COV_LIMIT:      cov_trace_limit   <= cfg_data;
        REG_JUMP_LIMIT:     jump_limit_mm     <= cfg_data[JUMP_W-1:0];
        REG_MAX_FIX_PERIOD: max_fix_period_us <= cfg_data;
        default: ;
      endcase
    end
  end

  // The squared jump limit is a register that follows the limit register in the next cycle.
  always_ff @(posedge clk) begin
    jump_limit_sq <= {{JUMP_W{1'b0}}, jump_limit_mm} * {{JUMP_W{1'b0}}, jump_limit_mm};
  end

  // Spacing to the previous fix, valid when it moves forward by more than the minimum.
  always_comb begin
    period       = {1'b0, item.stamp_us} - {1'b0, gnss_stamp};
    period_valid = !period[48] && (period[47:0] > MIN_PERIOD_US);
  end

  // Checks that evaluate takes from the state as it stands at acceptance.
  always_comb begin
    eval_check               = '0;
    eval_check.imu_ok        = is_fresh(item.stamp_us, imu_stamp, imu_timeout_us);
    eval_check.gnss_recent   = is_fresh(item.stamp_us, gnss_stamp, gnss_timeout_us);
    eval_check.wheel_recent  = is_fresh(item.stamp_us, wheel_stamp, wheel_timeout_us);
    eval_check.diag_gnss_ok  = diag_gnss_ok;
    eval_check.diag_wheel_ok = diag_wheel_ok;
    eval_check.diag_seen     = diag_seen;
    eval_check.cov_ok        = (cov_trace_limit == 32'd0) ||
                               (cov_trace <= {1'b0, cov_trace_limit});
    eval_check.rate_ok       = !have_prev_fix || (max_fix_period_us == 32'd0) ||
                               (fix_period <= {16'd0, max_fix_period_us});
    eval_check.jump_ok       = 1'b0;
    eval_check.innov_warn    = diag_gnss_innov > innovation_warn;
    eval_check.innov_fail    = diag_gnss_innov > innovation_fail;
    eval_check.gnss_innov    = diag_gnss_innov;
    eval_check.wheel_innov   = diag_wheel_innov;
  end

  // Event handling on the accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      diag_gnss_ok     <= 1'b0;
      diag_wheel_ok    <= 1'b0;
      diag_gnss_innov  <= '0;
      diag_wheel_innov <= '0;
      diag_seen        <= 1'b0;
      gnss_stamp       <= '0;
      imu_stamp        <= '0;
      wheel_stamp      <= '0;
      cov_trace        <= '0;
      have_prev_fix    <= 1'b0;
      prev_x           <= '0;
      prev_y           <= '0;
      fix_period       <= '1;
    end else if (accept) begin
      unique case (cmd)
        CMD_DIAG: begin
          diag_gnss_ok     <= item.gnss_accepted;
          diag_wheel_ok    <= item.wheel_accepted;
          diag_gnss_innov  <= item.gnss_innovation;
          diag_wheel_innov <= item.wheel_innovation;
          diag_seen        <= item.stamp_us != 48'd0;
        end
        CMD_GNSS: begin
          if (have_prev_fix && period_valid) begin
            fix_period <= period[47:0];
          end
          prev_x        <= item.pos_x_mm;
          prev_y        <= item.pos_y_mm;
          gnss_stamp    <= item.stamp_us;
          have_prev_fix <= 1'b1;
          cov_trace     <= {1'b0, item.cov_xx} + {1'b0, item.cov_yy};
        end
        CMD_IMU:   imu_stamp   <= item.stamp_us;
        CMD_WHEEL: wheel_stamp <= item.stamp_us;
        default: ;
      endcase
    end
  end

  // First stage: position differences and evaluate checks.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_fix  <= 1'b0;
      s1_eval <= 1'b0;
    end else begin
      s1_fix  <= accept && (cmd == CMD_GNSS) && have_prev_fix;
      s1_eval <= accept && (cmd == CMD_EVAL);
    end
    s1_mag_x     <= abs_diff(item.pos_x_mm, prev_x);
    s1_mag_y     <= abs_diff(item.pos_y_mm, prev_y);
    s1_check     <= eval_check;
    s1_have_prev <= have_prev_fix;
  end

  // Second stage: squares of the differences.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_fix  <= 1'b0;
      s2_eval <= 1'b0;
    end else begin
      s2_fix  <= s1_fix;
      s2_eval <= s1_eval;
    end
    s2_sq_x      <= {32'd0, s1_mag_x} * {32'd0, s1_mag_x};
    s2_sq_y      <= {32'd0, s1_mag_y} * {32'd0, s1_mag_y};
    s2_check     <= s1_check;
    s2_have_prev <= s1_have_prev;
  end

  // Third stage: saturated squared jump of a fix; the jump check is combinational.
  assign jump_sum = {1'b0, s2_sq_x} + {1'b0, s2_sq_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_sq <= '0;
    end else if (s2_fix) begin
      jump_sq <= jump_sum[64] ? '1 : jump_sum[63:0];
    end
  end

  always_comb begin
    check         = s2_check;
    check.jump_ok = !s2_have_prev || (jump_limit_mm == '0) ||
                    (jump_sq <= {24'd0, jump_limit_sq});
  end

  assign check_push    = s2_eval;
  assign eval_inflight = {1'b0, s1_eval} + {1'b0, s2_eval};

endmodule

@@ design/shms_fifo.sv @@
// Small queue of evaluate check records between the front and the back.
`timescale 1ns / 1ps

module shms_fifo #(
  parameter int DEPTH = shms_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  shms_pkg::check_t           din,
  input  logic                       pop,
  output shms_pkg::check_t           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import shms_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  check_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic          do_pop;

  assign empty  = count == '0;
  assign do_pop = pop && !empty;
  assign dout   = mem[rd_ptr];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !do_pop) begin
        count <= count + CW'(1);
      end else if (!push && do_pop) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ design/shms_back.sv @@
// Back part: confidence, mode selection and the result output register.
`timescale 1ns / 1ps

module shms_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              check_empty,
  input  shms_pkg::check_t  check,
  output logic              check_pop,
  input  logic              pop,
  output logic              empty,
  output shms_pkg::result_t result
);
  import shms_pkg::*;

  logic    out_valid;
  logic    gnss_trusted;
  logic    wheel_trusted;
  logic [7:0] penalty;
  logic [7:0] conf;
  mode_t   mode_sel;
  result_t result_next;

  assign check_pop = !check_empty && (!out_valid || pop);
  assign empty     = !out_valid;

  // Sensor verdicts and the confidence left after penalties.
  always_comb begin
    gnss_trusted  = check.gnss_recent && check.diag_gnss_ok && check.cov_ok &&
                    check.jump_ok && check.rate_ok;
    wheel_trusted = check.wheel_recent && (!check.diag_seen || check.diag_wheel_ok);
    penalty = (gnss_trusted     ? 8'd0 : PEN_GNSS)  +
              (wheel_trusted    ? 8'd0 : PEN_WHEEL) +
              (check.imu_ok     ? 8'd0 : PEN_IMU)   +
              (check.innov_warn ? PEN_INNOV : 8'd0) +
              (check.cov_ok     ? 8'd0 : PEN_COV)   +
              (check.jump_ok    ? 8'd0 : PEN_JUMP)  +
              (check.rate_ok    ? 8'd0 : PEN_RATE);
    conf = (penalty >= CONF_FULL) ? 8'd0 : CONF_FULL - penalty;
  end

  // Mode by priority; a failing innovation forces degraded.
  always_comb begin
    priority if (check.innov_fail) begin
      mode_sel = MODE_DEGRADED;
    end else if (!check.imu_ok) begin
      mode_sel = MODE_INVALID;
    end else if (!gnss_trusted && check.wheel_recent) begin
      mode_sel = MODE_DEAD_RECKONING;
    end else if (gnss_trusted && wheel_trusted && !check.innov_warn) begin
      mode_sel = MODE_NORMAL;
    end else if (gnss_trusted || check.wheel_recent) begin
      mode_sel = MODE_DEGRADED;
    end else begin
      mode_sel = MODE_INVALID;
    end
  end

  always_comb begin
    result_next.mode                 = mode_sel;
    result_next.confidence           = conf[6:0];
    result_next.gnss_trusted         = gnss_trusted;
    result_next.imu_good             = check.imu_ok;
    result_next.wheel_trusted        = wheel_trusted;
    result_next.healthy              = (mode_sel == MODE_NORMAL) ||
                                       (mode_sel == MODE_DEGRADED);
    result_next.gnss_innovation_out  = check.gnss_innov;
    result_next.wheel_innovation_out = check.wheel_innov;
  end

  // Output register: loads a waiting check when it is empty or its result transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (check_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (check_pop) begin
      result <= result_next;
    end
  end

endmodule
